### src/luma_contrast_normalizer_defines.svh
// assertion macros shared by the luma contrast normalizer modules
// expects clk and rst_n in the scope of each use
`ifndef LUMA_CONTRAST_NORMALIZER_DEFINES_SVH
`define LUMA_CONTRAST_NORMALIZER_DEFINES_SVH

// same-cycle implication
`define LCN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lcn_pkg.sv
// types, widths and constants of the luma contrast normalizer
// used by every module of the block, no dependencies
package lcn_pkg;

    localparam int MAX_PIXELS  = 65536;
    localparam int CNT_W       = 17;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 32;
    localparam int DIV_W       = 33;
    localparam int DEN_W       = 17;
    localparam int PROD_W      = 17;
    localparam int STEP_W      = 6;
    localparam int VAR_W       = 17;
    localparam int ROOT_W      = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] MID_LUMA = 8'd128;
    localparam logic [7:0] LUMA_MAX = 8'd255;

    localparam logic [STEP_W-1:0] ADJ_STEPS = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] FIN_STEPS = STEP_W'(DIV_W);

    typedef enum logic
    {
        OP_MEASURE = 1'b0,
        OP_ADJUST  = 1'b1
    } lcn_op_t;

    typedef enum logic
    {
        KIND_PIXEL  = 1'b0,
        KIND_REPORT = 1'b1
    } lcn_kind_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ADJ_MUL,
        ST_ADJ_DIV,
        ST_ADJ_WAIT,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_MS_DIV,
        ST_MS_WAIT,
        ST_VAR,
        ST_ROOT,
        ST_ROUND,
        ST_EMIT
    } lcn_state_t;

    typedef struct packed
    {
        lcn_op_t            op;
        logic [7:0]         luma;
        logic [7:0]         chroma_b;
        logic [7:0]         chroma_r;
        logic [8:0]         target;
        logic [CNT_W-1:0]   count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq_sum;
    } lcn_entry_t;

    typedef struct packed
    {
        logic               start;
        logic [DIV_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

    typedef struct packed
    {
        logic               busy;
        logic               done;
        logic [DIV_W-1:0]   quot;
    } div_rsp_t;

endpackage

### src/lcn_front.sv
// front end: request acceptance, statistics accumulation, queue writes
// depends on lcn_pkg
module lcn_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [7:0]        luma,
    input  logic [7:0]        chroma_b,
    input  logic [7:0]        chroma_r,
    input  logic              last,
    input  logic [8:0]        target_stddev,
    input  logic              q_full,
    output logic              q_push,
    output lcn_pkg::lcn_entry_t q_entry
);
    import lcn_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;

    logic             accept;
    logic             room;
    logic [15:0]      sq16;
    lcn_op_t          op;
    logic [CNT_W-1:0] cnt_acc;
    logic [SUM_W-1:0] sum_acc;
    logic [SQ_W-1:0]  sq_acc;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign op       = lcn_op_t'(req_type);
    assign sq16     = 16'(luma) * 16'(luma);
    assign room     = count_reg < CNT_W'(MAX_PIXELS);

    always_comb
    begin
        cnt_acc = count_reg;
        sum_acc = sum_reg;
        sq_acc  = sq_reg;
        if (room)
        begin
            cnt_acc = count_reg + CNT_W'(1);
            sum_acc = sum_reg + SUM_W'(luma);
            sq_acc  = sq_reg + SQ_W'(sq16);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        if (accept && op == OP_MEASURE)
        begin
            if (last)
            begin
                count_next = '0;
                sum_next   = '0;
                sq_next    = '0;
            end
            else
            begin
                count_next = cnt_acc;
                sum_next   = sum_acc;
                sq_next    = sq_acc;
            end
        end
    end

    always_comb
    begin
        q_push           = accept && (op == OP_ADJUST || last);
        q_entry.op       = op;
        q_entry.luma     = luma;
        q_entry.chroma_b = chroma_b;
        q_entry.chroma_r = chroma_r;
        q_entry.target   = target_stddev;
        q_entry.count    = cnt_acc;
        q_entry.sum      = sum_acc;
        q_entry.sq_sum   = sq_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
        end
    end

endmodule

### src/lcn_queue.sv
// short request queue between front and back ends
// depends on lcn_pkg and the assertion macro header
module lcn_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcn_pkg::lcn_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output lcn_pkg::lcn_entry_t rd_entry
);
    import lcn_pkg::*;
    `include "luma_contrast_normalizer_defines.svh"

    lcn_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign rd_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LCN_ASSERT_IMP(a_no_push_full, push, !full, "queue written while full")
    `LCN_ASSERT_IMP(a_no_pop_empty, pop, !empty, "queue read while empty")

endmodule

### src/lcn_div.sv
// restoring divider, one quotient bit per cycle, variable step count
// depends on lcn_pkg and the assertion macro header
module lcn_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lcn_pkg::div_req_t req,
    output lcn_pkg::div_rsp_t rsp
);
    import lcn_pkg::*;
    `include "luma_contrast_normalizer_defines.svh"

    logic [DIV_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_new;
    logic              fits;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_new = fits ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg  <= rem_new[DEN_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `LCN_ASSERT_IMP(a_start_idle, req.start, !busy_reg, "divider started while busy")

endmodule

### src/lcn_back.sv
// back end: statistics finish, pixel adjustment, output register
// depends on lcn_pkg, lcn_div and the assertion macro header
module lcn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  lcn_pkg::lcn_entry_t q_entry,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [7:0]          out_luma,
    output logic [7:0]          out_chroma_b,
    output logic [7:0]          out_chroma_r,
    output logic [7:0]          mean_luma,
    output logic [7:0]          std_luma
);
    import lcn_pkg::*;
    `include "luma_contrast_normalizer_defines.svh"

    lcn_state_t        state_reg, state_next;
    lcn_entry_t        entry_reg;
    logic [7:0]        mean_stat_reg;
    logic [7:0]        std_stat_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [7:0]        mean_tmp_reg;
    logic [VAR_W-1:0]  ms_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [3:0]        bit_reg;
    logic [7:0]        res_luma_reg;

    logic              out_valid_reg;
    lcn_kind_t         kind_reg;
    logic [7:0]        out_luma_reg, out_cb_reg, out_cr_reg, out_mean_reg, out_std_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic              emit_load;
    logic              slot_free;

    logic [CNT_W-1:0]  n_eff;
    logic [DIV_W-1:0]  mean_num, ms_num;
    logic [8:0]        diff;
    logic [7:0]        mag;
    logic [PROD_W-1:0] prod;
    logic [7:0]        d_eff;
    logic [PROD_W-1:0] q17;
    logic [7:0]        adj_luma;
    logic [7:0]        mean_sat;
    logic [15:0]       mean_sq;
    logic [VAR_W:0]    var_s;
    logic [VAR_W-1:0]  var_fl;
    logic [ROOT_W-1:0] trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [2*ROOT_W-1:0] root_sq;
    logic [ROOT_W:0]   root_rnd;
    logic [7:0]        root_sat;

    lcn_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign slot_free = !out_valid_reg || !out_stall;

    // datapath helpers
    always_comb
    begin
        n_eff    = (entry_reg.count == '0) ? CNT_W'(1) : entry_reg.count;
        mean_num = DIV_W'(entry_reg.sum) + DIV_W'(n_eff >> 1);
        ms_num   = DIV_W'(entry_reg.sq_sum) + DIV_W'(n_eff >> 1);

        diff = {1'b0, entry_reg.luma} - {1'b0, mean_stat_reg};
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
        prod = PROD_W'(mag) * PROD_W'(entry_reg.target);
        d_eff = (std_stat_reg == '0) ? 8'd1 : std_stat_reg;

        q17 = div_rsp.quot[PROD_W-1:0];
        if (neg_reg)
        begin
            adj_luma = (q17 > PROD_W'(MID_LUMA)) ? 8'd0 : 8'(PROD_W'(MID_LUMA) - q17);
        end
        else
        begin
            adj_luma = (q17 >= PROD_W'(MID_LUMA)) ? LUMA_MAX : 8'(PROD_W'(MID_LUMA) + q17);
        end

        mean_sat = (div_rsp.quot > DIV_W'(LUMA_MAX)) ? LUMA_MAX : div_rsp.quot[7:0];
        mean_sq  = 16'(mean_tmp_reg) * 16'(mean_tmp_reg);
        var_s    = {1'b0, ms_reg} - (VAR_W + 1)'(mean_sq);
        var_fl   = (var_s[VAR_W] || var_s == '0) ? VAR_W'(1) : var_s[VAR_W-1:0];

        trial    = root_reg | (ROOT_W'(1) << bit_reg);
        trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
        root_sq  = (2*ROOT_W)'(root_reg) * (2*ROOT_W)'(root_reg) + (2*ROOT_W)'(root_reg);
        root_rnd = {1'b0, root_reg}
                   + (ROOT_W + 1)'((2*ROOT_W)'(var_reg) > root_sq);
        root_sat = (root_rnd > (ROOT_W + 1)'(LUMA_MAX)) ? LUMA_MAX : root_rnd[7:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_entry.op == OP_ADJUST) ? ST_ADJ_MUL : ST_MEAN_DIV;
                end
            end
            ST_ADJ_MUL:   state_next = ST_ADJ_DIV;
            ST_ADJ_DIV:   state_next = ST_ADJ_WAIT;
            ST_ADJ_WAIT:  state_next = div_rsp.done ? ST_EMIT : ST_ADJ_WAIT;
            ST_MEAN_DIV:  state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: state_next = div_rsp.done ? ST_MS_DIV : ST_MEAN_WAIT;
            ST_MS_DIV:    state_next = ST_MS_WAIT;
            ST_MS_WAIT:   state_next = div_rsp.done ? ST_VAR : ST_MS_WAIT;
            ST_VAR:       state_next = ST_ROOT;
            ST_ROOT:      state_next = (bit_reg == '0) ? ST_ROUND : ST_ROOT;
            ST_ROUND:     state_next = ST_EMIT;
            ST_EMIT:      state_next = slot_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop         = 1'b0;
        emit_load     = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = mean_num;
        div_req.den   = DEN_W'(n_eff);
        div_req.steps = FIN_STEPS;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_ADJ_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'(prod_reg) << (DIV_W - PROD_W);
                div_req.den   = DEN_W'(d_eff);
                div_req.steps = ADJ_STEPS;
            end
            ST_MEAN_DIV:
            begin
                div_req.start = 1'b1;
            end
            ST_MS_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = ms_num;
            end
            ST_EMIT:
            begin
                emit_load = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            entry_reg <= q_entry;
        end
        if (state_reg == ST_ADJ_MUL)
        begin
            prod_reg <= prod;
            neg_reg  <= diff[8];
        end
        if (state_reg == ST_ADJ_WAIT && div_rsp.done)
        begin
            res_luma_reg <= adj_luma;
        end
        if (state_reg == ST_MEAN_WAIT && div_rsp.done)
        begin
            mean_tmp_reg <= mean_sat;
        end
        if (state_reg == ST_MS_WAIT && div_rsp.done)
        begin
            ms_reg <= div_rsp.quot[VAR_W-1:0];
        end
        if (state_reg == ST_VAR)
        begin
            var_reg  <= var_fl;
            root_reg <= '0;
            bit_reg  <= 4'(ROOT_W - 1);
        end
        if (state_reg == ST_ROOT)
        begin
            if (trial_sq <= (2*ROOT_W)'(var_reg))
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg - 4'd1;
        end
        if (emit_load)
        begin
            if (entry_reg.op == OP_ADJUST)
            begin
                kind_reg     <= KIND_PIXEL;
                out_luma_reg <= res_luma_reg;
                out_cb_reg   <= entry_reg.chroma_b;
                out_cr_reg   <= entry_reg.chroma_r;
            end
            else
            begin
                kind_reg     <= KIND_REPORT;
                out_luma_reg <= '0;
                out_cb_reg   <= '0;
                out_cr_reg   <= '0;
            end
            out_mean_reg <= mean_stat_reg;
            out_std_reg  <= std_stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mean_stat_reg <= 8'd0;
            std_stat_reg  <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ROUND)
            begin
                mean_stat_reg <= mean_tmp_reg;
                std_stat_reg  <= root_sat;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_luma     = out_luma_reg;
    assign out_chroma_b = out_cb_reg;
    assign out_chroma_r = out_cr_reg;
    assign mean_luma    = out_mean_reg;
    assign std_luma     = out_std_reg;

    `LCN_ASSERT_IMP(a_std_nonzero, 1'b1, std_stat_reg != 8'd0, "stored deviation is zero")
    `LCN_ASSERT_IMP(a_done_waiting, div_rsp.done,
        state_reg == ST_ADJ_WAIT || state_reg == ST_MEAN_WAIT || state_reg == ST_MS_WAIT,
        "divider result outside a wait state")
    `LCN_ASSERT_NXT(a_emit_lands, emit_load, out_valid_reg && state_reg == ST_IDLE,
        "emitted result not in output register")

endmodule

### src/luma_contrast_normalizer.sv
// Luma contrast normalizer top level.
// Input channel: in_valid / in_stall with req_type, luma, chroma_b, chroma_r,
// last and target_stddev. A request is taken when in_valid is high and
// in_stall is low.
// Measure requests add luma to the chip statistics in the front end, one per
// cycle while in_stall is low, and give no result unless marked last. A last
// measure is queued and, after it leaves the queue, yields a report (kind 1)
// with the new rounded mean and deviation, from two 33-step divisions and a
// 9-step square root.
// Adjust requests yield one pixel (kind 0) after leaving the queue, using
// the 17-step shared divider; the back end takes no new request from the
// queue until the previous result has been loaded into the output register.
// A two-entry queue sits between front and back; in_stall is high while it
// is full. Results leave through out_valid / out_stall from an output
// register; while out_stall is high the result holds and the back end waits
// after finishing the next one.
// Reset clears the statistics, sets the stored mean to 0 and the stored
// deviation to 1, and empties the queue and output register.
// depends on lcn_pkg, lcn_front, lcn_queue, lcn_div, lcn_back
module luma_contrast_normalizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] luma,
    input  logic [7:0] chroma_b,
    input  logic [7:0] chroma_r,
    input  logic       last,
    input  logic [8:0] target_stddev,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_luma,
    output logic [7:0] out_chroma_b,
    output logic [7:0] out_chroma_r,
    output logic [7:0] mean_luma,
    output logic [7:0] std_luma
);
    import lcn_pkg::*;

    logic       q_full, q_empty, q_push, q_pop;
    lcn_entry_t wr_entry, rd_entry;

    lcn_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .luma          (luma),
        .chroma_b      (chroma_b),
        .chroma_r      (chroma_r),
        .last          (last),
        .target_stddev (target_stddev),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (wr_entry)
    );

    lcn_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (rd_entry)
    );

    lcn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_entry      (rd_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_luma     (out_luma),
        .out_chroma_b (out_chroma_b),
        .out_chroma_r (out_chroma_r),
        .mean_luma    (mean_luma),
        .std_luma     (std_luma)
    );

endmodule
